FILE: design/setq_pkg.sv
// ---------------------------------------------------------------------------
// setq_pkg
// Shared widths, action codes and controller/datapath command and status
// types for the sorted event timer queue.
// ---------------------------------------------------------------------------
`default_nettype none

package setq_pkg;

   localparam int ACT_W = 2;
   localparam int LEN_W = 8;
   localparam int EVT_W = 8;
   localparam int SEC_W = 24;

   localparam logic [SEC_W-1:0] SEC_MAX = '1;

   typedef enum logic [ACT_W-1:0] {
      ACT_POLL   = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_CANCEL = 2'd2,
      ACT_CLEAR  = 2'd3
   } setq_action_type;

   typedef struct packed {
      logic [SEC_W-1:0] end_sec;
      logic [EVT_W-1:0] event_id;
   } setq_slot_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the request item
      logic prep;      // tick counter, compute new end, reset scan state
      logic issue;     // read the slot at the scan address
      logic commit;    // apply add/pop and load the result register
   } setq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;
      logic is_clear;
      logic out_free;
   } setq_status_type;

endpackage

`default_nettype wire

FILE: design/setq_channels.sv
// ---------------------------------------------------------------------------
// setq channels
// Valid/ready request and response channels of the sorted event timer queue.
// ---------------------------------------------------------------------------
`default_nettype none

interface setq_req_if;
   logic                        valid;
   logic                        ready;
   logic [setq_pkg::ACT_W-1:0]  action;
   logic                        second_tick;
   logic [setq_pkg::LEN_W-1:0]  length_min;
   logic [setq_pkg::EVT_W-1:0]  event_id;

   modport source (output valid, action, second_tick, length_min, event_id,
                   input ready);
   modport sink   (input valid, action, second_tick, length_min, event_id,
                   output ready);
endinterface

interface setq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        expired_valid;
   logic [setq_pkg::EVT_W-1:0]  expired_event;
   logic [setq_pkg::SEC_W-1:0]  next_remaining_sec;
   logic                        add_rejected;

   modport source (output valid, expired_valid, expired_event, next_remaining_sec,
                   add_rejected, input ready);
   modport sink   (input valid, expired_valid, expired_event, next_remaining_sec,
                   add_rejected, output ready);
endinterface

`default_nettype wire

FILE: design/setq_datapath.sv
// ---------------------------------------------------------------------------
// setq_datapath
// Slot memory, valid bits, seconds counter, sequential earliest-deadline scan
// and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module setq_datapath #(
   parameter int TIMER_SLOTS        = 16,
   parameter int SECONDS_PER_MINUTE = 60
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [setq_pkg::ACT_W-1:0]   req_action,
   input  wire logic                         req_second_tick,
   input  wire logic [setq_pkg::LEN_W-1:0]   req_length_min,
   input  wire logic [setq_pkg::EVT_W-1:0]   req_event_id,
   input  wire setq_pkg::setq_cmd_type       cmd,
   output      setq_pkg::setq_status_type    stat,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_valid,
   output      logic                         rsp_expired_valid,
   output      logic [setq_pkg::EVT_W-1:0]   rsp_expired_event,
   output      logic [setq_pkg::SEC_W-1:0]   rsp_next_remaining_sec,
   output      logic                         rsp_add_rejected
);
   import setq_pkg::*;

   localparam int IDX_W  = $clog2(TIMER_SLOTS);
   localparam int SPM_W  = $clog2(SECONDS_PER_MINUTE + 1);
   localparam int PROD_W = LEN_W + SPM_W;
   localparam int SUM_W  = ((PROD_W > SEC_W) ? PROD_W : SEC_W) + 1;

   // request latch
   setq_action_type  act_ff;
   logic             tick_ff;
   logic [LEN_W-1:0] len_ff;
   logic [EVT_W-1:0] evt_ff;

   // counter and new end
   logic [SEC_W-1:0]  cur_ff, cur_in;
   logic [SEC_W-1:0]  new_end_ff, new_end_in;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  sum;

   // slot store
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   setq_slot_type          slot_mem [TIMER_SLOTS];

   // scan pipeline
   logic [IDX_W-1:0] scan_addr_ff;
   logic             cmp_go_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   setq_slot_type    rd_ff;
   logic             cmp_slot_v, cmp_match, cmp_take, cmp_kill, cmp_free;

   // scan results
   logic             best_v_ff;
   logic [SEC_W-1:0] best_end_ff;
   logic [EVT_W-1:0] best_evt_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic             sec_v_ff;
   logic [SEC_W-1:0] sec_end_ff;
   logic             free_v_ff;
   logic [IDX_W-1:0] free_idx_ff;

   // finish
   logic             due, pop, store, src_v;
   logic [SEC_W-1:0] src_end, rem_in;

   // result register
   logic             out_valid_ff;
   logic             exp_v_ff;
   logic [EVT_W-1:0] exp_evt_ff;
   logic [SEC_W-1:0] rem_ff;
   logic             rej_ff;

   // ---------------- request latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= setq_action_type'(req_action);
         tick_ff <= req_second_tick;
         len_ff  <= req_length_min;
         evt_ff  <= req_event_id;
      end
   end

   // ---------------- counter and new end second
   assign prod = PROD_W'(len_ff) * PROD_W'(SECONDS_PER_MINUTE);
   assign sum  = SUM_W'(cur_ff) + SUM_W'(prod);
   assign new_end_in = (sum > SUM_W'(SEC_MAX)) ? SEC_MAX : sum[SEC_W-1:0];

   always_comb begin
      cur_in = cur_ff;
      if (cmd.prep && act_ff == ACT_POLL && tick_ff && cur_ff != SEC_MAX) begin
         cur_in = cur_ff + SEC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         new_end_ff <= new_end_in;
      end
   end

   // ---------------- scan: read one slot per cycle, compare the registered slot
   assign cmp_slot_v = valid_ff[cmp_idx_ff];
   assign cmp_match  = (act_ff == ACT_CANCEL) && (rd_ff.event_id == evt_ff);
   assign cmp_take   = cmp_go_ff && cmp_slot_v && !cmp_match;
   assign cmp_kill   = cmp_go_ff && cmp_slot_v && cmp_match;
   assign cmp_free   = cmp_go_ff && !cmp_slot_v;

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_ff <= slot_mem[scan_addr_ff];
      end
      if (cmd.commit && store) begin
         slot_mem[free_idx_ff] <= '{end_sec: new_end_ff, event_id: evt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         cmp_go_ff    <= 1'b0;
         best_v_ff    <= 1'b0;
         sec_v_ff     <= 1'b0;
         free_v_ff    <= 1'b0;
      end else begin
         cmp_go_ff <= cmd.issue;
         if (cmd.issue) begin
            cmp_idx_ff   <= scan_addr_ff;
            scan_addr_ff <= scan_addr_ff + IDX_W'(1);
         end
         if (cmd.prep) begin
            scan_addr_ff <= '0;
            best_v_ff    <= 1'b0;
            sec_v_ff     <= 1'b0;
            free_v_ff    <= 1'b0;
         end else begin
            // keep the two earliest; ascending scan with strict compare
            // leaves the lowest slot first on equal ends
            if (cmp_take) begin
               if (!best_v_ff || rd_ff.end_sec < best_end_ff) begin
                  sec_v_ff    <= best_v_ff;
                  sec_end_ff  <= best_end_ff;
                  best_v_ff   <= 1'b1;
                  best_end_ff <= rd_ff.end_sec;
                  best_evt_ff <= rd_ff.event_id;
                  best_idx_ff <= cmp_idx_ff;
               end else if (!sec_v_ff || rd_ff.end_sec < sec_end_ff) begin
                  sec_v_ff   <= 1'b1;
                  sec_end_ff <= rd_ff.end_sec;
               end
            end
            if (cmp_free && !free_v_ff) begin
               free_v_ff   <= 1'b1;
               free_idx_ff <= cmp_idx_ff;
            end
         end
      end
   end

   // ---------------- finish: pop or store, then time left to earliest
   assign due   = best_v_ff && (best_end_ff <= cur_ff);
   assign pop   = (act_ff == ACT_POLL) && due;
   assign store = (act_ff == ACT_ADD) && free_v_ff;

   always_comb begin
      src_v   = best_v_ff;
      src_end = best_end_ff;
      case (act_ff)
         ACT_POLL: begin
            if (due) begin
               src_v   = sec_v_ff;
               src_end = sec_end_ff;
            end
         end
         ACT_ADD: begin
            if (store && (!best_v_ff || new_end_ff < best_end_ff)) begin
               src_v   = 1'b1;
               src_end = new_end_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rem_in = (src_v && src_end > cur_ff) ? (src_end - cur_ff) : '0;

   // ---------------- valid bits
   always_comb begin
      valid_in = valid_ff;
      if (cmd.prep && act_ff == ACT_CLEAR) begin
         valid_in = '0;
      end
      if (cmp_kill) begin
         valid_in[cmp_idx_ff] = 1'b0;
      end
      if (cmd.commit && pop) begin
         valid_in[best_idx_ff] = 1'b0;
      end
      if (cmd.commit && store) begin
         valid_in[free_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         exp_v_ff   <= pop;
         exp_evt_ff <= pop ? best_evt_ff : '0;
         rem_ff     <= rem_in;
         rej_ff     <= (act_ff == ACT_ADD) && !free_v_ff;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_expired_valid      = exp_v_ff;
   assign rsp_expired_event      = exp_evt_ff;
   assign rsp_next_remaining_sec = rem_ff;
   assign rsp_add_rejected       = rej_ff;

   assign stat.scan_last = (scan_addr_ff == IDX_W'(TIMER_SLOTS - 1));
   assign stat.is_clear  = (act_ff == ACT_CLEAR);
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   // ---------------- assertions
   a_store_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && store) |=> valid_ff[$past(free_idx_ff)])
      else $error("stored slot not marked valid");

   a_counter_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (cur_ff >= $past(cur_ff)))
      else $error("seconds counter went backward");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(exp_v_ff && rej_ff))
      else $error("result reports both expiry and rejection");

   a_commit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

FILE: design/setq_ctrl.sv
// ---------------------------------------------------------------------------
// setq_ctrl
// Sequencer for one item: latch, prepare, scan all slots, drain the compare
// stage, then commit into the result register; clear skips scan and drain.
// ---------------------------------------------------------------------------
`default_nettype none

module setq_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire setq_pkg::setq_status_type  stat,
   output      setq_pkg::setq_cmd_type     cmd
);
   import setq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= ST_PREP;
                  ready_ff <= 1'b0;
               end
            end
            ST_PREP: begin
               // clear needs no scan: the table is empty afterwards
               state_ff <= stat.is_clear ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
               if (stat.scan_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold until the result register can take the item
               if (stat.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready   = ready_ff;
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid && ready_ff;
   assign cmd.prep    = (state_ff == ST_PREP);
   assign cmd.issue   = (state_ff == ST_SCAN);
   assign cmd.commit  = (state_ff == ST_FINISH) && stat.out_free;

endmodule

`default_nettype wire

FILE: design/sorted_event_timer_queue.sv
// ---------------------------------------------------------------------------
// sorted_event_timer_queue
// Earliest-deadline-first table of one-shot timers with a seconds counter.
//
// Usage: req_chan carries one action per item (poll, add, cancel, clear)
// with its tick, length and event id; rsp_chan returns exactly one result
// item per request: expired event, seconds to the earliest timer, and the
// add rejection flag. Both channels move an item when valid and ready are
// high at a rising clock edge.
// Sequence: the request is latched, then prepared, all slots are scanned,
// the compare stage drains and the item is committed into the result
// register; clear skips the scan and drain. The next request is taken only
// after that commit; the scan reads one slot of the slot memory per cycle.
// Stall: the finished result sits in an output register, so the next request
// is taken and worked on while it waits; that request's commit holds until
// the output register is free.
// Reset: synchronous, active high; the table is empty and the counter is 0.
// No clearing pass is needed, valid bits are flip-flops.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_event_timer_queue #(
   parameter int TIMER_SLOTS        = 16,
   parameter int SECONDS_PER_MINUTE = 60
) (
   input  wire logic   clock,
   input  wire logic   reset,
   setq_req_if.sink    req_chan,
   setq_rsp_if.source  rsp_chan
);
   import setq_pkg::*;

   setq_cmd_type    cmd;
   setq_status_type stat;

   setq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   setq_datapath #(
      .TIMER_SLOTS        (TIMER_SLOTS),
      .SECONDS_PER_MINUTE (SECONDS_PER_MINUTE)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .req_action             (req_chan.action),
      .req_second_tick        (req_chan.second_tick),
      .req_length_min         (req_chan.length_min),
      .req_event_id           (req_chan.event_id),
      .cmd                    (cmd),
      .stat                   (stat),
      .rsp_ready              (rsp_chan.ready),
      .rsp_valid              (rsp_chan.valid),
      .rsp_expired_valid      (rsp_chan.expired_valid),
      .rsp_expired_event      (rsp_chan.expired_event),
      .rsp_next_remaining_sec (rsp_chan.next_remaining_sec),
      .rsp_add_rejected       (rsp_chan.add_rejected)
   );

endmodule

`default_nettype wire
